### hdl/arp_pkg.sv
// Package for the ARP responder: microcode word layout, codes and the control store.
`timescale 1ns / 1ps

package arp_pkg;

    localparam int HDR_LEN   = 42;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 6;
    localparam int STEP_W    = 6;
    localparam int N_CHECK   = 8;
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0]  CNT_MAX   = 6'd63;
    localparam logic [CNT_W-1:0]  CNT_FULL  = 6'(HDR_LEN - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = 6'(N_CHECK + HDR_LEN - 1);

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd1;

    localparam logic [7:0] C_ETYPE_HI = 8'h08;
    localparam logic [7:0] C_ETYPE_LO = 8'h06;
    localparam logic [7:0] C_PTYPE_LO = 8'h00;
    localparam logic [7:0] C_OP_REQ   = 8'h01;
    localparam logic [7:0] C_OP_REP   = 8'h02;
    localparam logic [7:0] C_ZERO     = 8'h00;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_CMP  = 2'd1,
        OP_EMIT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_HDR   = 2'd1,
        SRC_MAC   = 2'd2,
        SRC_IP    = 2'd3
    } t_src;

    typedef struct packed {
        t_op               op;
        t_src              src;
        logic [2:0]        sel;
        logic [7:0]        konst;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_uword;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // header entry whose byte the given step consumes
    function automatic logic [ADDR_W-1:0] hdr_addr(logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] e;
        logic [ADDR_W-1:0] a;
        e = step - 6'(N_CHECK);
        a = '0;
        if (step == 6'd1) begin
            a = 6'd12;
        end else if (step == 6'd2) begin
            a = 6'd13;
        end else if (step == 6'd3) begin
            a = 6'd21;
        end else if (step >= 6'd4 && step < 6'(N_CHECK)) begin
            a = step + 6'd34;
        end else if (step >= 6'(N_CHECK) && step <= LAST_STEP) begin
            if (e < 6'd6) begin
                a = e + 6'd22;
            end else if (e == 6'd14 || e == 6'd15 || e == 6'd18 || e == 6'd19) begin
                a = e;
            end else if (e >= 6'd32) begin
                a = e - 6'd10;
            end
        end
        return a;
    endfunction

    function automatic t_uword rom_word(logic [STEP_W-1:0] step);
        t_uword w;
        logic [STEP_W-1:0] e;
        w.op    = OP_READ;
        w.src   = SRC_CONST;
        w.sel   = '0;
        w.konst = C_ZERO;
        w.last  = 1'b0;
        e = step - 6'(N_CHECK);
        if (step == 6'd1) begin
            w.op = OP_CMP;  w.konst = C_ETYPE_HI;
        end else if (step == 6'd2) begin
            w.op = OP_CMP;  w.konst = C_ETYPE_LO;
        end else if (step == 6'd3) begin
            w.op = OP_CMP;  w.konst = C_OP_REQ;
        end else if (step >= 6'd4 && step < 6'(N_CHECK)) begin
            w.op = OP_CMP;  w.src = SRC_IP;  w.sel = 3'(step - 6'd4);
        end else if (step >= 6'(N_CHECK)) begin
            w.op   = OP_EMIT;
            w.last = (step == LAST_STEP);
            if (e < 6'd6) begin
                w.src = SRC_HDR;
            end else if (e < 6'd12) begin
                w.src = SRC_MAC;  w.sel = 3'(e - 6'd6);
            end else if (e == 6'd12) begin
                w.konst = C_ETYPE_HI;
            end else if (e == 6'd13) begin
                w.konst = C_ETYPE_LO;
            end else if (e == 6'd16) begin
                w.konst = C_ETYPE_HI;
            end else if (e == 6'd17) begin
                w.konst = C_PTYPE_LO;
            end else if (e == 6'd20) begin
                w.konst = C_ZERO;
            end else if (e == 6'd21) begin
                w.konst = C_OP_REP;
            end else if (e >= 6'd22 && e < 6'd28) begin
                w.src = SRC_MAC;  w.sel = 3'(e - 6'd22);
            end else if (e >= 6'd28 && e < 6'd32) begin
                w.src = SRC_IP;   w.sel = 3'(e - 6'd28);
            end else begin
                w.src = SRC_HDR;
            end
        end
        // prefetch the entry that the next step needs
        w.addr = hdr_addr(step + 6'd1);
        return w;
    endfunction

endpackage

### hdl/arp_request_responder_unit.sv
// ARP responder: frame capture store, microcoded check and reply sequencer.
`timescale 1ns / 1ps
// Receive: one word per cycle while idle; the header store is written at the accept edge.
// After the last word of a matching frame: 8 check steps, then 42 reply words, one per
// cycle unless the output stalls; input is stalled until the last reply word is issued.
// A non-matching frame of 42 words or more stalls input until the first failing compare,
// longer while an earlier reply word is still held by an output stall.
// Synchronous active-low reset clears sequencer, count, output valid and registers.
module arp_request_responder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [arp_pkg::MAC_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_frame_byte,
    input  logic                            i_frame_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_reply_byte,
    output logic                            o_reply_end
);

    logic [arp_pkg::MAC_W-1:0]  r_mac;
    logic [arp_pkg::IP_W-1:0]   r_ip;
    arp_pkg::t_state            r_state, n_state;
    logic [arp_pkg::CNT_W-1:0]  r_count;
    logic [arp_pkg::STEP_W-1:0] r_step;
    logic [7:0]                 r_store [arp_pkg::HDR_LEN];
    logic [7:0]                 r_rd;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_end;

    arp_pkg::t_uword            w_uw;
    logic [7:0]                 w_operand;
    logic                       w_accept;
    logic                       w_adv;

    assign w_uw     = arp_pkg::rom_word(r_step);
    assign w_accept = i_in_valid && (r_state == arp_pkg::ST_IDLE);
    assign w_adv    = (r_state == arp_pkg::ST_RUN) && !(r_out_valid && i_out_stall);

    assign o_in_stall   = (r_state != arp_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_reply_byte = r_out_byte;
    assign o_reply_end  = r_out_end;

    always_comb begin
        unique case (w_uw.src)
            arp_pkg::SRC_CONST: w_operand = w_uw.konst;
            arp_pkg::SRC_HDR:   w_operand = r_rd;
            arp_pkg::SRC_MAC:   w_operand = r_mac[8 * (3'd5 - w_uw.sel) +: 8];
            arp_pkg::SRC_IP:    w_operand = r_ip[8 * (2'd3 - w_uw.sel[1:0]) +: 8];
            default:            w_operand = w_uw.konst;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arp_pkg::ST_IDLE: begin
                // frame of at least 42 words ends: start the program
                if (w_accept && i_frame_end && r_count >= arp_pkg::CNT_FULL) begin
                    n_state = arp_pkg::ST_RUN;
                end
            end
            arp_pkg::ST_RUN: begin
                if (w_adv) begin
                    if (w_uw.op == arp_pkg::OP_CMP && w_operand != r_rd) begin
                        n_state = arp_pkg::ST_IDLE;
                    end else if (w_uw.op == arp_pkg::OP_EMIT && w_uw.last) begin
                        n_state = arp_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = arp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0;
            r_ip  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == arp_pkg::REG_OWN_MAC) begin
                r_mac <= i_cfg_data;
            end else if (i_cfg_index == arp_pkg::REG_OWN_IP) begin
                r_ip <= i_cfg_data[arp_pkg::IP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arp_pkg::ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (i_frame_end) begin
                    r_count <= '0;
                end else if (r_count != arp_pkg::CNT_MAX) begin
                    r_count <= r_count + 6'd1;
                end
            end
            if (n_state == arp_pkg::ST_RUN && w_adv) begin
                r_step <= r_step + 6'd1;
            end else if (n_state == arp_pkg::ST_IDLE) begin
                r_step <= '0;
            end
        end
    end

    // header store: first 42 words written on receive, read one entry per sequencer step and while idle
    always_ff @(posedge i_clk) begin
        if (w_accept && r_count <= arp_pkg::CNT_FULL) begin
            r_store[r_count] <= i_frame_byte;
        end
        if (w_adv || r_state == arp_pkg::ST_IDLE) begin
            r_rd <= r_store[w_uw.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_uw.op == arp_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_uw.op == arp_pkg::OP_EMIT) begin
            r_out_byte <= w_operand;
            r_out_end  <= w_uw.last;
        end
    end

endmodule
